/* rtl/ppsf_pkg.sv */
`default_nettype none
package ppsf_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;

   // filter taps for partial-sum cells, nearest cell first
   localparam int TAP_COUNT = 4;
   localparam int TAP_COEF [TAP_COUNT] = '{4, 10, 4, -1};
   localparam int OUT_COEF_SHIFT = 4;
   localparam int ROUND_BIAS = 8;

   localparam logic [2:0] COUNT_FULL = 3'd4;

   localparam logic [15:0] QUAT_W_ONE = 16'h4000;
   localparam logic [63:0] QUAT_IDENTITY = {QUAT_W_ONE, 48'h0};

   typedef struct packed {
      logic head_en;
      logic head_filt;
      logic tail_en;
      logic last;
   } grp_ctrl_type;

endpackage
`default_nettype wire

/* rtl/ppsf_tap_cell.sv */
`default_nettype none
module ppsf_tap_cell import ppsf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int SUM_BITS = POSITION_BITS_DEFAULT + 6,
   parameter int COEF = 1
) (
   input  wire logic                         clock,
   input  wire logic                         shift_en,
   input  wire logic signed [POSITION_BITS-1:0] cur,
   input  wire logic signed [SUM_BITS-1:0]   sum_in,
   output logic signed [SUM_BITS-1:0]        sum_out
);

   logic signed [SUM_BITS-1:0] cur_ext;
   logic signed [SUM_BITS-1:0] coef_c;
   logic signed [SUM_BITS-1:0] acc_in;
   logic signed [SUM_BITS-1:0] acc_ff;

   assign cur_ext = {{(SUM_BITS-POSITION_BITS){cur[POSITION_BITS-1]}}, cur};
   assign coef_c  = SUM_BITS'(COEF);
   assign acc_in  = sum_in + coef_c * cur_ext;
   assign sum_out = acc_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/ppsf_emitter.sv */
`default_nettype none
module ppsf_emitter import ppsf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int SUM_BITS = POSITION_BITS_DEFAULT + 6,
   parameter int DATA_BITS = 192
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire grp_ctrl_type                    ctrl,
   input  wire logic signed [SUM_BITS-1:0]      fir_sum [3],
   input  wire logic signed [POSITION_BITS-1:0] cur_pos [3],
   input  wire logic [63:0]                     cur_quat,
   input  wire logic [31:0]                     cur_stamp,
   input  wire logic signed [POSITION_BITS-1:0] prev_pos [3],
   input  wire logic [63:0]                     prev_quat,
   input  wire logic [31:0]                     prev_stamp,
   input  wire logic [31:0]                     filt_stamp,
   output logic                                 load_ready,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [DATA_BITS-1:0]                 rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int Q_BITS = SUM_BITS - OUT_COEF_SHIFT;
   localparam logic [2:0] SLOT_HEAD = 3'b001;
   localparam logic [2:0] SLOT_PREV = 3'b010;
   localparam logic [2:0] SLOT_TAIL = 3'b100;

   logic [2:0] pend_ff, pend_in;
   logic       filt_ff, last_ff;
   logic signed [SUM_BITS-1:0]      g_sum_ff [3];
   logic signed [POSITION_BITS-1:0] g_cur_ff [3];
   logic signed [POSITION_BITS-1:0] g_prev_ff [3];
   logic [63:0] g_cur_quat_ff, g_prev_quat_ff;
   logic [31:0] g_cur_stamp_ff, g_prev_stamp_ff, g_filt_stamp_ff;

   logic                 out_vld_ff, out_vld_in;
   logic [DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                 out_user_ff, out_user_in;
   logic                 out_last_ff, out_last_in;

   logic [2:0] sel, rest;
   logic       can_adv;
   logic signed [Q_BITS-1:0]        q [3];
   logic signed [POSITION_BITS-1:0] sat [3];
   logic signed [POSITION_BITS-1:0] it_pos [3];
   logic [63:0] it_quat;
   logic [31:0] it_stamp;
   logic        it_smooth;

   assign sel        = pend_ff & (~pend_ff + 3'd1);
   assign rest       = pend_ff & ~sel;
   assign can_adv    = !out_vld_ff || rsp_tready;
   assign load_ready = (pend_ff == 3'd0) || (can_adv && (rest == 3'd0));

   for (genvar a = 0; a < 3; a++) begin : g_sat
      assign q[a] = Q_BITS'(g_sum_ff[a] >>> OUT_COEF_SHIFT);
      always_comb begin
         if (q[a][Q_BITS-1:POSITION_BITS-1] == '0 ||
             q[a][Q_BITS-1:POSITION_BITS-1] == '1) begin
            sat[a] = q[a][POSITION_BITS-1:0];
         end else if (q[a][Q_BITS-1]) begin
            sat[a] = {1'b1, {(POSITION_BITS-1){1'b0}}};
         end else begin
            sat[a] = {1'b0, {(POSITION_BITS-1){1'b1}}};
         end
      end
   end

   always_comb begin
      it_pos    = g_cur_ff;
      it_quat   = g_cur_quat_ff;
      it_stamp  = g_cur_stamp_ff;
      it_smooth = 1'b0;
      case (sel)
         SLOT_HEAD: begin
            if (filt_ff) begin
               it_pos    = sat;
               it_quat   = QUAT_IDENTITY;
               it_stamp  = g_filt_stamp_ff;
               it_smooth = 1'b1;
            end
         end
         SLOT_PREV: begin
            it_pos   = g_prev_ff;
            it_quat  = g_prev_quat_ff;
            it_stamp = g_prev_stamp_ff;
         end
         SLOT_TAIL: begin
            it_pos = g_cur_ff;
         end
         default: begin
            it_pos = g_cur_ff;
         end
      endcase
   end

   always_comb begin
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      out_user_in = out_user_ff;
      out_last_in = out_last_ff;
      if (can_adv) begin
         pend_in     = rest;
         out_vld_in  = (pend_ff != 3'd0);
         out_data_in = DATA_BITS'({it_stamp, it_quat, it_pos[2], it_pos[1], it_pos[0]});
         out_user_in = it_smooth;
         out_last_in = last_ff && (rest == 3'd0);
      end
      if (load) begin
         pend_in = {ctrl.tail_en, ctrl.tail_en, ctrl.head_en};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 3'd0;
         out_vld_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
      if (load) begin
         filt_ff         <= ctrl.head_filt;
         last_ff         <= ctrl.last;
         g_sum_ff        <= fir_sum;
         g_cur_ff        <= cur_pos;
         g_prev_ff       <= prev_pos;
         g_cur_quat_ff   <= cur_quat;
         g_prev_quat_ff  <= prev_quat;
         g_cur_stamp_ff  <= cur_stamp;
         g_prev_stamp_ff <= prev_stamp;
         g_filt_stamp_ff <= filt_stamp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

/* rtl/path_point_smoothing_fir_core.sv */
// channel | dir | tdata (low bit up)                                | tuser    | tlast
// req     | in  | pos_x, pos_y, pos_z, quat_x/y/z/w, stamp, zero pad | -        | last_point
// rsp     | out | out_x, out_y, out_z, out_qx/qy/qz/qw, out_stamp    | smoothed | end_of_path
//
// One word accepted per cycle while each word yields at most one result word and
// rsp_tready does not stall the output register. A word yielding two or three
// results holds req_tready low while the output register drains the group buffer.
// The first result passes through the group buffer and then the output register.
// Synchronous reset clears the point count, the group buffer's pending flags and rsp_tvalid.
`default_nettype none
module path_point_smoothing_fir_core import ppsf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   localparam int DATA_BITS = ((3 * POSITION_BITS + 96 + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, stamp
   input  wire logic [DATA_BITS-1:0] req_tdata,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw, out_stamp
   output logic [DATA_BITS-1:0]      rsp_tdata,
   // smoothed
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int SUM_BITS = POSITION_BITS + 6;

   logic accept;
   logic signed [POSITION_BITS-1:0] cur_pos [3];
   logic [63:0] cur_quat;
   logic [31:0] cur_stamp;
   logic signed [SUM_BITS-1:0] part [3][TAP_COUNT];
   logic signed [SUM_BITS-1:0] fir_sum [3];

   logic signed [POSITION_BITS-1:0] prev_pos_ff [3];
   logic [63:0] prev_quat_ff;
   logic [31:0] stamp0_ff, stamp1_ff;
   logic [2:0]  count_ff, count_in;
   grp_ctrl_type ctrl;

   assign accept    = req_tvalid && req_tready;
   assign cur_quat  = req_tdata[3*POSITION_BITS +: 64];
   assign cur_stamp = req_tdata[3*POSITION_BITS+64 +: 32];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign cur_pos[a] = req_tdata[a*POSITION_BITS +: POSITION_BITS];
      for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
         logic signed [SUM_BITS-1:0] sum_in;
         if (k == TAP_COUNT - 1) begin : g_end
            assign sum_in = SUM_BITS'(ROUND_BIAS);
         end else begin : g_mid
            assign sum_in = part[a][k+1];
         end
         ppsf_tap_cell #(
            .POSITION_BITS(POSITION_BITS),
            .SUM_BITS     (SUM_BITS),
            .COEF         (TAP_COEF[k])
         ) u_cell (
            .clock   (clock),
            .shift_en(accept),
            .cur     (cur_pos[a]),
            .sum_in  (sum_in),
            .sum_out (part[a][k])
         );
      end
      assign fir_sum[a] = part[a][0] -
                          {{(SUM_BITS-POSITION_BITS){cur_pos[a][POSITION_BITS-1]}},
                           cur_pos[a]};
   end

   always_comb begin
      ctrl.head_en   = (count_ff < 3'd2) || (count_ff == COUNT_FULL);
      ctrl.head_filt = (count_ff == COUNT_FULL);
      ctrl.tail_en   = req_tlast && (count_ff != 3'd0);
      ctrl.last      = req_tlast;
      count_in = count_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in = 3'd0;
         end else if (count_ff != COUNT_FULL) begin
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_pos_ff  <= cur_pos;
         prev_quat_ff <= cur_quat;
         stamp0_ff    <= cur_stamp;
         stamp1_ff    <= stamp0_ff;
      end
   end

   ppsf_emitter #(
      .POSITION_BITS(POSITION_BITS),
      .SUM_BITS     (SUM_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .ctrl      (ctrl),
      .fir_sum   (fir_sum),
      .cur_pos   (cur_pos),
      .cur_quat  (cur_quat),
      .cur_stamp (cur_stamp),
      .prev_pos  (prev_pos_ff),
      .prev_quat (prev_quat_ff),
      .prev_stamp(stamp0_ff),
      .filt_stamp(stamp1_ff),
      .load_ready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire

/* rtl/ppsf_checker.sv */
`default_nettype none
module ppsf_checker import ppsf_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   localparam int DATA_BITS = ((3 * POSITION_BITS + 96 + 7) / 8) * 8
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [DATA_BITS-1:0] rsp_tdata,
   input wire logic                 rsp_tuser,
   input wire logic                 rsp_tlast
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_filt_orient: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[3*POSITION_BITS +: 64] == QUAT_IDENTITY)
      else $error("smoothed word without identity orientation");

   a_filt_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("smoothed word marked as end of path");

endmodule

bind path_point_smoothing_fir_core ppsf_checker #(
   .POSITION_BITS(POSITION_BITS)
) u_ppsf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
`default_nettype wire
